>>> sv/three_channel_moving_average_macros.svh
// ---------------------------------------------------------------------------
// three_channel_moving_average_macros
// assertion macros shared by the moving average block
// ---------------------------------------------------------------------------
`ifndef THREE_CHANNEL_MOVING_AVERAGE_MACROS_SVH
`define THREE_CHANNEL_MOVING_AVERAGE_MACROS_SVH

`ifndef ASSERT_OFF

`define TCMA_ASSERT_SAME(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("assertion failed");

`define TCMA_ASSERT_NEXT(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");

`else

`define TCMA_ASSERT_SAME(name, cond, conseq)

`define TCMA_ASSERT_NEXT(name, cond, conseq)

`endif

`endif

>>> sv/tcma_pkg.sv
// ---------------------------------------------------------------------------
// tcma_pkg
// types and constants of the three channel moving average
// ---------------------------------------------------------------------------
package tcma_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int ENTRY_W       = SAMPLE_BITS + 2;
  localparam int OFFSET_W      = 9;
  localparam int DEPTH_DEFAULT = 8;
  localparam int IN_DATA_W     = 16;
  localparam int UNS_MEAN_W    = 10;
  localparam int SGN_MEAN_W    = 12;
  localparam int OUT_DATA_W    = 2 * UNS_MEAN_W + SGN_MEAN_W;
  localparam int OUT_USER_W    = 2;

  typedef enum logic [1:0] {
    CH_LEFT  = 2'd0,
    CH_RIGHT = 2'd1,
    CH_THUMB = 2'd2
  } chan_t;

  typedef logic signed [ENTRY_W-1:0] entry_t;

endpackage

>>> sv/tcma_ram.sv
// ---------------------------------------------------------------------------
// tcma_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module tcma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/tcma_chan.sv
// ---------------------------------------------------------------------------
// tcma_chan
// one channel: ring buffer in ram, write position and running sum
// ---------------------------------------------------------------------------
module tcma_chan #(
  parameter int DEPTH = tcma_pkg::DEPTH_DEFAULT
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  wr_en,
  input  tcma_pkg::entry_t                                      wr_data,
  output logic signed [tcma_pkg::ENTRY_W+$clog2(DEPTH)-1:0]     sum_upd
);

  import tcma_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = ENTRY_W + AW;

  logic [AW-1:0]             pos;
  logic [AW-1:0]             pos_next;
  logic                      wrapped;
  logic                      at_last;
  logic [ENTRY_W-1:0]        rd_data;
  entry_t                    old_entry;
  logic signed [SUM_W-1:0]   sum;

  assign at_last  = (pos == AW'(DEPTH - 1));
  assign pos_next = !wr_en ? pos : (at_last ? '0 : pos + AW'(1));

  // entries at or past the write position are zero until the ring wraps
  assign old_entry = wrapped ? entry_t'(rd_data) : '0;
  assign sum_upd   = wr_en ? sum + SUM_W'(wr_data) - SUM_W'(old_entry) : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      wrapped <= 1'b0;
      sum     <= '0;
    end else begin
      pos <= pos_next;
      sum <= sum_upd;
      if (wr_en && at_last) begin
        wrapped <= 1'b1;
      end
    end
  end

  // read ahead at the next write position so the old entry is ready
  tcma_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_addr (pos_next),
    .rd_data (rd_data)
  );

endmodule

>>> sv/tcma_skid.sv
// ---------------------------------------------------------------------------
// tcma_skid
// output register with skid stage for the result stream
// ---------------------------------------------------------------------------
module tcma_skid #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             out_free;

  assign in_ready = !skid_valid;
  assign out_free = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

>>> sv/three_channel_moving_average.sv
// ---------------------------------------------------------------------------
// three_channel_moving_average
// round robin boxcar averager over left, right and thumb adc channels
// ---------------------------------------------------------------------------
// each input item on s_axis carries one adc sample; items go to the left,
// right and thumb channels in turn, starting with left after reset.
// right samples get the signed cfg offset added before they are stored.
// every item yields one result item on m_axis: the channel written in
// tuser and the three running averages in tdata.
// each result is registered in the skid output stage; one item per cycle
// is sustained while m_axis takes them: each channel keeps a running sum
// and a ring in ram that is read one position ahead, so an update is one
// add and subtract. reset clears the sums, positions, wrap flags, channel
// turn and offset at once. when m_axis stalls, a skid stage takes one more
// item, then s_axis_tready drops until m_axis accepts the item it holds.
// ---------------------------------------------------------------------------
`include "three_channel_moving_average_macros.svh"

module three_channel_moving_average #(
  parameter int DEPTH = tcma_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tcma_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tcma_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // left_mean, right_mean, thumb_mean
  output logic [tcma_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // channel_written
  input  logic                             cfg_wr_en,
  input  logic [tcma_pkg::OFFSET_W-1:0]    cfg_wr_data    // right_offset
);

  import tcma_pkg::*;

  localparam int SUM_W = ENTRY_W + $clog2(DEPTH);
  localparam int SHIFT = $clog2(DEPTH + 1) - 1;
  localparam int RES_W = OUT_USER_W + OUT_DATA_W;

  logic signed [OFFSET_W-1:0] right_offset;
  chan_t                      turn;
  chan_t                      turn_next;
  logic                       accept;
  logic                       wr_left;
  logic                       wr_right;
  logic                       wr_thumb;
  entry_t                     plain_entry;
  entry_t                     right_entry;
  logic signed [SUM_W-1:0]    sum_left;
  logic signed [SUM_W-1:0]    sum_right;
  logic signed [SUM_W-1:0]    sum_thumb;
  logic signed [SUM_W-1:0]    sh_left;
  logic signed [SUM_W-1:0]    sh_right;
  logic signed [SUM_W-1:0]    sh_thumb;
  chan_t                      chan_written;
  logic [RES_W-1:0]           res_data;
  logic [RES_W-1:0]           out_data;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign wr_left  = accept && (turn == CH_LEFT);
  assign wr_right = accept && (turn == CH_RIGHT);
  assign wr_thumb = accept && !(turn == CH_LEFT) && !(turn == CH_RIGHT);

  assign plain_entry = entry_t'(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign right_entry = plain_entry + ENTRY_W'(right_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      right_offset <= '0;
    end else if (cfg_wr_en) begin
      right_offset <= cfg_wr_data;
    end
  end

  always_comb begin
    unique case (turn)
      CH_LEFT:  turn_next = CH_RIGHT;
      CH_RIGHT: turn_next = CH_THUMB;
      default:  turn_next = CH_LEFT;
    endcase
  end

  always_comb begin
    unique case (turn)
      CH_LEFT:  chan_written = CH_LEFT;
      CH_RIGHT: chan_written = CH_RIGHT;
      default:  chan_written = CH_THUMB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn <= CH_LEFT;
    end else if (accept) begin
      turn <= turn_next;
    end
  end

  tcma_chan #(.DEPTH(DEPTH)) u_left (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_left),
    .wr_data (plain_entry),
    .sum_upd (sum_left)
  );

  tcma_chan #(.DEPTH(DEPTH)) u_right (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_right),
    .wr_data (right_entry),
    .sum_upd (sum_right)
  );

  tcma_chan #(.DEPTH(DEPTH)) u_thumb (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_thumb),
    .wr_data (plain_entry),
    .sum_upd (sum_thumb)
  );

  assign sh_left  = sum_left >>> SHIFT;
  assign sh_right = sum_right >>> SHIFT;
  assign sh_thumb = sum_thumb >>> SHIFT;

  assign res_data = {chan_written, sh_thumb[UNS_MEAN_W-1:0], sh_right[SGN_MEAN_W-1:0],
                     sh_left[UNS_MEAN_W-1:0]};

  tcma_skid #(.WIDTH(RES_W)) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (res_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = out_data[OUT_DATA_W-1:0];
  assign m_axis_tuser = out_data[RES_W-1:OUT_DATA_W];

  `TCMA_ASSERT_NEXT(a_turn_hold, !accept, turn == $past(turn))
  `TCMA_ASSERT_NEXT(a_left_then_right, accept && (turn == CH_LEFT), turn == CH_RIGHT)
  `TCMA_ASSERT_SAME(a_skid_needs_out, !s_axis_tready, m_axis_tvalid)
  `TCMA_ASSERT_NEXT(a_accept_gives_result, accept, m_axis_tvalid)

endmodule
